// File: src/nvds_pkg.sv
// shared types, constants and helpers for the nearest value distance set
package nvds_pkg;

   localparam int VALUE_W    = 32;
   localparam int COST_W     = 32;
   localparam int TOTAL_W    = 64;
   localparam int TREE_FANIN = 16;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic signed [VALUE_W-1:0] query;
      logic                      cmp_en;
      logic                      shift_en;
      logic                      insert_en;
   } nvds_ctrl_type;

   // neighbor contribution of one cell, zero unless the cell sits on a boundary
   typedef struct packed {
      logic                      have_lo;
      logic                      have_hi;
      logic signed [VALUE_W-1:0] lo_value;
      logic signed [VALUE_W-1:0] hi_value;
   } nvds_leaf_type;

   localparam int LEAF_W = $bits(nvds_leaf_type);

   // number of registered levels of the reduction tree
   function automatic int tree_levels(int leaves);
      int     levels;
      longint span;
      levels = 0;
      span   = 1;
      while (span < leaves) begin
         span   = span * TREE_FANIN;
         levels = levels + 1;
      end
      return levels;
   endfunction

endpackage

// File: src/nvds_cell.sv
// one storage cell of the sorted chain: compare, boundary detect and shift
module nvds_cell import nvds_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 11
) (
   input  logic                      clock,
   input  nvds_ctrl_type             ctrl,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic                      left_lt,
   input  logic                      right_lt,
   output logic signed [VALUE_W-1:0] value,
   output logic                      lt,
   output nvds_leaf_type             leaf
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      lt_ff, lt_in;
   nvds_leaf_type             leaf_ff, leaf_in;
   logic                      occupied;

   assign occupied = CNT_W'(INDEX) < count;

   always_comb begin
      lt_in    = lt_ff;
      leaf_in  = leaf_ff;
      value_in = value_ff;
      if (ctrl.cmp_en) begin
         lt_in = occupied && (value_ff < ctrl.query);
      end
      if (ctrl.shift_en) begin
         // last cell below the query, first occupied cell at or above it
         leaf_in.have_lo  = lt_ff && !right_lt;
         leaf_in.have_hi  = !lt_ff && left_lt && occupied;
         leaf_in.lo_value = leaf_in.have_lo ? value_ff : '0;
         leaf_in.hi_value = leaf_in.have_hi ? value_ff : '0;
         if (ctrl.insert_en && !lt_ff) begin
            value_in = left_lt ? ctrl.query : left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      leaf_ff  <= leaf_in;
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign leaf  = leaf_ff;

endmodule

// File: src/nvds_or_tree.sv
// registered or-reduction tree that collects the one-hot neighbor contributions
module nvds_or_tree import nvds_pkg::*; #(
   parameter int LEAVES = 1024,
   parameter int WIDTH  = 66
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   localparam int LEVELS = tree_levels(LEAVES);

   logic [WIDTH-1:0] node_ff [1:LEVELS][LEAVES];

   for (genvar k = 1; k <= LEVELS; k++) begin : g_level
      localparam int SPAN       = TREE_FANIN ** k;
      localparam int SPAN_PREV  = SPAN / TREE_FANIN;
      localparam int NODES      = (LEAVES + SPAN - 1) / SPAN;
      localparam int NODES_PREV = (LEAVES + SPAN_PREV - 1) / SPAN_PREV;
      for (genvar j = 0; j < NODES; j++) begin : g_node
         logic [WIDTH-1:0] part [TREE_FANIN];
         logic [WIDTH-1:0] node_in;
         for (genvar m = 0; m < TREE_FANIN; m++) begin : g_part
            localparam int SRC = j * TREE_FANIN + m;
            if (SRC >= NODES_PREV) begin : g_pad
               assign part[m] = '0;
            end else if (k == 1) begin : g_leaf
               assign part[m] = leaf[SRC];
            end else begin : g_inner
               assign part[m] = node_ff[k-1][SRC];
            end
         end
         always_comb begin
            node_in = '0;
            for (int m = 0; m < TREE_FANIN; m++) begin
               node_in = node_in | part[m];
            end
         end
         always_ff @(posedge clock) begin
            node_ff[k][j] <= node_in;
         end
      end
   end

   assign root = node_ff[LEVELS][0];

endmodule

// File: src/nearest_value_distance_set.sv
// top level: sorted value set held in a chain of cells, nearest neighbor distance per transfer
// per request: compare, shift, tree walk over LEVELS = ceil(log16(CAPACITY)) levels, distance, sum
// one request at a time: a new request is taken only after the result is loaded into the output register
// default CAPACITY of 1024 gives 3 tree levels
// reset: synchronous, clears entry count, running total and handshake state
// stored values are not cleared; only cells below the entry count are ever looked at
module nearest_value_distance_set import nvds_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COST_W-1:0]         rsp_cost,
   output logic [TOTAL_W-1:0]        rsp_running_total,
   output logic                      rsp_store_full
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LEVELS = tree_levels(CAPACITY);
   localparam int LVL_W  = $clog2(LEVELS + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CMP    = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_DIST   = 3'd4;
   localparam logic [2:0] ST_SUM    = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [LVL_W-1:0]          lvl_ff, lvl_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0] query_ff, query_in;
   logic                      full_ff, full_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;

   // distance stage
   logic [COST_W-1:0]         dlo_ff, dlo_in;
   logic [COST_W-1:0]         dhi_ff, dhi_in;
   logic [COST_W-1:0]         abs_ff, abs_in;
   logic                      have_lo_ff, have_lo_in;
   logic                      have_hi_ff, have_hi_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]         rsp_cost_ff, rsp_cost_in;
   logic [TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;
   logic                      rsp_full_ff, rsp_full_in;

   logic                      store_full;
   logic                      req_xfer;
   logic                      out_load;
   nvds_ctrl_type             ctrl;
   nvds_leaf_type             root;
   logic [LEAF_W-1:0]         root_vec;

   // chain wiring
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic                      cell_lt    [CAPACITY];
   nvds_leaf_type             cell_leaf  [CAPACITY];
   logic [LEAF_W-1:0]         leaf_vec   [CAPACITY];

   // distance arithmetic, one bit wider so the difference never overflows
   logic signed [VALUE_W:0]   diff_lo, diff_hi, neg_query;
   logic [COST_W-1:0]         cost_sel;

   assign store_full = count_ff == CNT_W'(CAPACITY);
   assign req_ready  = state_ff == ST_IDLE;
   assign req_xfer   = req_valid && req_ready;
   // the result waits here if the previous one has not been taken yet
   assign out_load   = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_ready);

   assign ctrl.query     = query_ff;
   assign ctrl.cmp_en    = state_ff == ST_CMP;
   assign ctrl.shift_en  = state_ff == ST_SHIFT;
   assign ctrl.insert_en = !store_full;

   // the cell chain: cell 0 sees a virtual "less than" on its left
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic                      left_lt;
      logic                      right_lt;
      if (i == 0) begin : g_first
         assign left_value = query_ff;
         assign left_lt    = 1'b1;
      end else begin : g_inner
         assign left_value = cell_value[i-1];
         assign left_lt    = cell_lt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_lt = 1'b0;
      end else begin : g_mid
         assign right_lt = cell_lt[i+1];
      end
      nvds_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .left_value (left_value),
         .left_lt    (left_lt),
         .right_lt   (right_lt),
         .value      (cell_value[i]),
         .lt         (cell_lt[i]),
         .leaf       (cell_leaf[i])
      );
      assign leaf_vec[i] = cell_leaf[i];
   end

   // at most one lower and one upper boundary cell, so or-ing picks them out
   nvds_or_tree #(
      .LEAVES (CAPACITY),
      .WIDTH  (LEAF_W)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf_vec),
      .root  (root_vec)
   );

   assign root = root_vec;

   always_comb begin
      diff_lo   = {query_ff[VALUE_W-1], query_ff} - {root.lo_value[VALUE_W-1], root.lo_value};
      diff_hi   = {root.hi_value[VALUE_W-1], root.hi_value} - {query_ff[VALUE_W-1], query_ff};
      neg_query = -{query_ff[VALUE_W-1], query_ff};
   end

   // nearest of the neighbors that exist, absolute value on an empty set
   always_comb begin
      priority if (have_lo_ff && have_hi_ff) begin
         cost_sel = (dlo_ff < dhi_ff) ? dlo_ff : dhi_ff;
      end else if (have_lo_ff) begin
         cost_sel = dlo_ff;
      end else if (have_hi_ff) begin
         cost_sel = dhi_ff;
      end else begin
         cost_sel = abs_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      count_in     = count_ff;
      query_in     = query_ff;
      full_in      = full_ff;
      total_in     = total_ff;
      dlo_in       = dlo_ff;
      dhi_in       = dhi_ff;
      abs_in       = abs_ff;
      have_lo_in   = have_lo_ff;
      have_hi_in   = have_hi_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_total_in = rsp_total_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               query_in = req_value;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // boundary leaves latch and the chain shifts on the same edge
            full_in = store_full;
            if (!store_full) begin
               count_in = count_ff + CNT_W'(1);
            end
            lvl_in   = '0;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            lvl_in = lvl_ff + LVL_W'(1);
            if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            dlo_in     = diff_lo[COST_W-1:0];
            dhi_in     = diff_hi[COST_W-1:0];
            abs_in     = query_ff[VALUE_W-1] ? neg_query[COST_W-1:0] : query_ff;
            have_lo_in = root.have_lo;
            have_hi_in = root.have_hi;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            if (out_load) begin
               total_in     = total_ff + TOTAL_W'(cost_sel);
               rsp_cost_in  = cost_sel;
               rsp_total_in = total_ff + TOTAL_W'(cost_sel);
               rsp_full_in  = full_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      full_ff      <= full_in;
      dlo_ff       <= dlo_in;
      dhi_ff       <= dhi_in;
      abs_ff       <= abs_in;
      have_lo_ff   <= have_lo_in;
      have_hi_ff   <= have_hi_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_total_ff <= rsp_total_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cost          = rsp_cost_ff;
   assign rsp_running_total = rsp_total_ff;
   assign rsp_store_full    = rsp_full_ff;

endmodule

// File: src/nvds_checker.sv
// port-level checker for the nearest value distance set, bound to the top level
module nvds_checker import nvds_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COST_W-1:0]         rsp_cost,
   input logic [TOTAL_W-1:0]        rsp_running_total,
   input logic                      rsp_store_full
);

   logic [TOTAL_W-1:0] last_total_ff;
   logic [1:0]         pending_ff;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               rsp_fresh_ff;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
         pending_ff    <= '0;
         rsp_fresh_ff  <= 1'b1;
      end else begin
         if (rsp_xfer) begin
            last_total_ff <= rsp_running_total;
         end
         pending_ff   <= pending_ff + 2'(req_xfer) - 2'(rsp_xfer);
         rsp_fresh_ff <= !rsp_valid || rsp_ready;
      end
   end

   // no result is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a waiting result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_total)
         && $stable(rsp_cost) && $stable(rsp_store_full))
      else $error("stalled result changed");

   // every result belongs to an accepted request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without a request");

   // each new running total is the previous one plus this cost
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fresh_ff |->
         rsp_running_total == last_total_ff + TOTAL_W'(rsp_cost))
      else $error("running total does not follow the cost");

   logic unused_req_value;
   assign unused_req_value = ^req_value;

   // the request field is sampled only to tie off the bound port
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> unused_req_value == ^req_value)
      else $error("request value sampling mismatch");

endmodule

bind nearest_value_distance_set nvds_checker u_nvds_checker (.*);
